// ===== src/pdat_pkg.sv =====
// Package with shared types and constants of the packet delivery ack tracker.
`default_nettype none
package pdat_pkg;
	localparam int SEQ_BITS    = 16;
	localparam int ACK_WINDOW  = 32;
	localparam int QUEUE_DEPTH = 32;
	localparam int MAX_RESULTS = 33;
	localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int RES_BITS    = $clog2(MAX_RESULTS + 1);
	localparam logic [SEQ_BITS-1:0] SEQ_HALF = {1'b1, {(SEQ_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		KIND_SEND = 2'd0,
		KIND_ACK  = 2'd1,
		KIND_TICK = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		EV_SENT      = 3'd0,
		EV_DELIVERED = 3'd1,
		EV_DROPPED   = 3'd2,
		EV_NOTHING   = 3'd3,
		EV_UNTRACKED = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEND,
		ST_READ,
		ST_EVAL,
		ST_DONE
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic latch;
		logic do_send;
		logic step;
		logic finish;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic more;   // head entry needs work and result budget remains
		logic is_send;
	} dp_sts_t;

	function automatic logic seq_after(input logic [SEQ_BITS-1:0] a,
			input logic [SEQ_BITS-1:0] b);
		logic [SEQ_BITS-1:0] d;
		d = a - b;
		return (d != '0) && (d <= SEQ_HALF) && (a > b) ||
			(a < b) && ((b - a) > SEQ_HALF);
	endfunction
endpackage
`default_nettype wire

// ===== src/pdat_ctrl.sv =====
// Controller state machine of the packet delivery ack tracker.
`default_nettype none
module pdat_ctrl import pdat_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	output dp_cmd_t      cmd,
	input  dp_sts_t      sts
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_READ;
			ST_READ: begin
				if (sts.is_send) state_d = ST_SEND;
				else state_d = ST_EVAL;
			end
			ST_SEND: state_d = ST_IDLE;
			ST_EVAL: if (!sts.more) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: cmd.latch = start;
			ST_SEND: cmd.do_send = 1'b1;
			ST_EVAL: cmd.step = 1'b1;
			ST_DONE: cmd.finish = 1'b1;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/pdat_dp.sv =====
// Datapath of the packet delivery ack tracker: in-flight queue and walk logic.
`default_nettype none
module pdat_dp import pdat_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  dp_cmd_t                  cmd,
	output dp_sts_t                  sts,
	input  wire logic                process_acks,
	input  wire logic [15:0]         timeout_ticks,
	input  wire logic [1:0]          kind,
	input  wire logic [31:0]         now_time,
	input  wire logic [15:0]         client_tag,
	input  wire logic [15:0]         latest_ack,
	input  wire logic [31:0]         ack_mask,
	output logic                     strobe,
	output logic [2:0]               event_res,
	output logic [15:0]              seq_num,
	output logic [15:0]              client_out,
	output logic                     last
);
	logic [SEQ_BITS-1:0] mem_seq [QUEUE_DEPTH];
	logic [15:0]         mem_cli [QUEUE_DEPTH];
	logic [31:0]         mem_time[QUEUE_DEPTH];

	logic [1:0]          kind_q;
	logic [31:0]         now_q;
	logic [15:0]         tag_q;
	logic [SEQ_BITS-1:0] latest_q;
	logic [31:0]         mask_q;
	logic [SEQ_BITS-1:0] pos_q;
	logic [SEQ_BITS-1:0] next_seq_q;
	logic [PTR_BITS-1:0] head_q;
	logic [CNT_BITS-1:0] count_q;
	logic [RES_BITS-1:0] nres_q;
	logic [SEQ_BITS-1:0] hseq_q;
	logic [15:0]         hcli_q;
	logic [31:0]         htime_q;
	logic                hvalid_q;
	logic [2:0]          hold_ev_q;
	logic [15:0]         hold_seq_q;
	logic [15:0]         hold_cli_q;

	// The head entry is read into registers; a pop reads the next one ahead.
	logic [PTR_BITS-1:0] head_nx, rd_addr, wr_addr;
	logic [CNT_BITS:0]   wr_sum;
	logic                pop, move_pos, cont, got, tmo, full;
	logic [SEQ_BITS-1:0] idx;
	logic [31:0]         age;

	assign full = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign head_nx = (head_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign wr_sum = (CNT_BITS+1)'(head_q) + (CNT_BITS+1)'(count_q);
	assign wr_addr = (wr_sum >= (CNT_BITS+1)'(QUEUE_DEPTH)) ?
		PTR_BITS'(wr_sum - (CNT_BITS+1)'(QUEUE_DEPTH)) : PTR_BITS'(wr_sum);
	assign age = now_q - htime_q;
	assign tmo = (age > {16'd0, timeout_ticks}) && !age[31];
	assign idx = latest_q - 1'b1 - pos_q;
	assign got = (pos_q == latest_q) ||
		((idx < SEQ_BITS'(32)) && mask_q[idx[4:0]]);

	always_comb begin
		cont = 1'b0;
		pop = 1'b0;
		move_pos = 1'b0;
		if (count_q != '0 && nres_q != RES_BITS'(MAX_RESULTS)) begin
			case (kind_q)
				KIND_ACK: begin
					if (pos_q == latest_q || seq_after(latest_q, pos_q)) begin
						cont = 1'b1;
						if (seq_after(pos_q, hseq_q)) pop = 1'b1;
						else if (pos_q == hseq_q) pop = 1'b1;
						else move_pos = 1'b1;
					end
				end
				KIND_TICK: begin
					cont = tmo;
					pop = tmo;
				end
				default: cont = 1'b0;
			endcase
		end
	end

	assign rd_addr = (cmd.step && pop) ? head_nx : head_q;
	assign sts.more = cont;
	assign sts.is_send = (kind_q == KIND_SEND);

	always_ff @(posedge clk) begin
		if (cmd.do_send && process_acks && !full) begin
			mem_seq[wr_addr]  <= next_seq_q;
			mem_cli[wr_addr]  <= tag_q;
			mem_time[wr_addr] <= now_q;
		end
		hseq_q  <= mem_seq[rd_addr];
		hcli_q  <= mem_cli[rd_addr];
		htime_q <= mem_time[rd_addr];
		if (cmd.latch) begin
			kind_q   <= kind;
			now_q    <= now_time;
			tag_q    <= client_tag;
			latest_q <= latest_ack;
			mask_q   <= ack_mask;
			pos_q    <= latest_ack - SEQ_BITS'(ACK_WINDOW);
		end else if (cmd.step && cont) begin
			if (move_pos) pos_q <= hseq_q;
			else if (pos_q == hseq_q) pos_q <= pos_q + 1'b1;
		end
		// Each popped entry's fate is held until it is known whether another follows.
		if (cmd.step && pop) begin
			hold_ev_q  <= (kind_q == KIND_ACK && pos_q == hseq_q && got) ?
				EV_DELIVERED : EV_DROPPED;
			hold_seq_q <= hseq_q;
			hold_cli_q <= hcli_q;
		end
		if (cmd.do_send) begin
			event_res  <= (process_acks && !full) ? EV_SENT : EV_UNTRACKED;
			seq_num    <= next_seq_q;
			client_out <= tag_q;
		end else if (cmd.step && (pop || !cont)) begin
			event_res  <= hold_ev_q;
			seq_num    <= hold_seq_q;
			client_out <= hold_cli_q;
		end else if (cmd.finish && nres_q == '0) begin
			event_res  <= EV_NOTHING;
			seq_num    <= '0;
			client_out <= '0;
		end
	end

	// hvalid_q marks a pending result that waits for the next step or end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q <= '0;
			head_q     <= '0;
			count_q    <= '0;
			nres_q     <= '0;
			hvalid_q   <= 1'b0;
			strobe     <= 1'b0;
			last       <= 1'b0;
		end else begin
			strobe <= 1'b0;
			last   <= 1'b0;
			if (cmd.latch) begin
				nres_q   <= '0;
				hvalid_q <= 1'b0;
			end
			if (cmd.do_send) begin
				next_seq_q <= next_seq_q + 1'b1;
				if (process_acks && !full) count_q <= count_q + 1'b1;
				strobe <= 1'b1;
				last   <= 1'b1;
			end
			if (cmd.step) begin
				if (pop) begin
					head_q   <= head_nx;
					count_q  <= count_q - 1'b1;
					nres_q   <= nres_q + 1'b1;
					hvalid_q <= 1'b1;
					// A held result goes out now; the new one waits.
					strobe   <= hvalid_q;
				end else if (!cont) begin
					strobe   <= hvalid_q;
					last     <= hvalid_q;
					hvalid_q <= 1'b0;
				end
			end
			if (cmd.finish) begin
				strobe <= (nres_q == '0);
				last   <= (nres_q == '0);
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/pdat_regs.sv =====
// Configuration registers of the packet delivery ack tracker on an APB-style port.
`default_nettype none
module pdat_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic             process_acks,
	output logic [15:0]      timeout_ticks
);
	localparam logic [2:0] ADDR_PROC = 3'd0;
	localparam logic [2:0] ADDR_TMO  = 3'd4;
	logic proc_q;
	logic [15:0] tmo_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign process_acks = proc_q;
	assign timeout_ticks = tmo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_q <= 1'b1;
			tmo_q  <= 16'd600;
		end else if (wr) begin
			if (paddr == ADDR_PROC) proc_q <= pwdata[0];
			if (paddr == ADDR_TMO) tmo_q <= pwdata[15:0];
		end
	end

	always_comb begin
		case (paddr)
			ADDR_PROC: prdata = {31'd0, proc_q};
			ADDR_TMO:  prdata = {16'd0, tmo_q};
			default:   prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/packet_delivery_ack_tracker.sv =====
// Top level of the packet delivery ack tracker.
// A send passes through the READ and SEND states and is busy meanwhile; its one result is
// registered from the SEND state, and a new item is accepted only once busy has fallen.
// An ack or tick pops one entry per cycle, save where a step moves the window position instead;
// for n resolved entries the window position jumps at most n + 1 times.
// Results wait for the next pop or the walk's end so the final one can carry last; the receiver
// cannot stall. Asynchronous active-low reset empties the queue and loads default registers.
`default_nettype none
module packet_delivery_ack_tracker import pdat_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] now_time,
	input  wire logic [15:0] client_tag,
	input  wire logic [15:0] latest_ack,
	input  wire logic [31:0] ack_mask,
	output logic             strobe,
	output logic [2:0]       event_res,
	output logic [15:0]      seq_num,
	output logic [15:0]      client_out,
	output logic             last
);
	logic process_acks;
	logic [15:0] timeout_ticks;
	dp_cmd_t cmd;
	dp_sts_t sts;

	// Register block: the user must write it only while no item is in flight; the block does not enforce this.
	pdat_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.process_acks, .timeout_ticks
	);

	// The controller sequences reads of the queue head and one evaluation per cycle.
	pdat_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .cmd, .sts);

	// The datapath holds the queue, the window position and the result registers.
	pdat_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .process_acks, .timeout_ticks,
		.kind, .now_time, .client_tag, .latest_ack, .ack_mask,
		.strobe, .event_res, .seq_num, .client_out, .last
	);
endmodule
`default_nettype wire

// ===== src/pdat_checker.sv =====
// Port-level checker for the packet delivery ack tracker and its bind.
`default_nettype none
module pdat_checker import pdat_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       strobe,
	input wire logic       last,
	input wire logic [2:0] event_res
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept without busy");
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe) else $error("last without strobe");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> !strobe) else $error("result while idle");
	a_nothing_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && event_res == EV_NOTHING |-> last) else $error("nothing not last");
endmodule

bind packet_delivery_ack_tracker pdat_checker u_chk (
	.clk, .arst_n, .start, .busy, .strobe, .last, .event_res
);
`default_nettype wire
